### hdl/bud_pkg.sv
// ----------------------------------------------------------------------------
// bud_pkg
// Shared types and constants for the binary buddy allocator.
// ----------------------------------------------------------------------------
package bud_pkg;

    localparam int DEF_HEAP_ORDER   = 16;
    localparam int DEF_HEADER_BYTES = 16;
    // order field of a block header, wide enough for the largest heap order
    localparam int ORD_W            = 5;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_NOMEM = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIZE,
        ST_SCAN,
        ST_SCAN_RD,
        ST_SPLIT,
        ST_FCHK,
        ST_FRD,
        ST_MERGE,
        ST_MRD,
        ST_WALK,
        ST_WRD,
        ST_UNL_END,
        ST_PUSH
    } bud_state_t;

    function automatic int min_order(input int header_bytes);
        if (header_bytes > 32)
        begin
            return 6;
        end
        else if (header_bytes > 16)
        begin
            return 5;
        end
        else if (header_bytes > 8)
        begin
            return 4;
        end
        return 3;
    endfunction

endpackage

### hdl/bud_ram.sv
// ----------------------------------------------------------------------------
// bud_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bud_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/buddy_allocator.sv
// ----------------------------------------------------------------------------
// buddy_allocator
// Binary buddy allocator with free lists per order and a header RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the single result word appears on status/addr with done high for one
// cycle, which the receiver must take as it comes. A small sequencer drives one
// header RAM port and one free-list head register file, one step per cycle.
// Allocate: a size order search, then a scan up the orders that skips each
// empty order and reads the head of a non-empty one, then one split per order.
// Free: checks of the address and its header, then per merge level a buddy
// read, plus a walk of the free list to unlink a buddy (the walk is bounded
// by the slot count).
// heap_base is written through cfg_valid/cfg_data and must only change idle.
module buddy_allocator #(
    parameter int HEAP_ORDER   = bud_pkg::DEF_HEAP_ORDER,
    parameter int HEADER_BYTES = bud_pkg::DEF_HEADER_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [31:0] req_size,
    input  logic [31:0] free_addr,
    output logic        done,
    output logic        status,
    output logic [31:0] addr,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    import bud_pkg::*;

    localparam int MIN_ORD = min_order(HEADER_BYTES);
    localparam int SB      = HEAP_ORDER - MIN_ORD;
    localparam int SW      = SB + 1;
    localparam int SLOTS   = 1 << SB;
    localparam int HW      = SW + 1 + ORD_W;
    localparam int HI_W    = $clog2(HEAP_ORDER + 1);
    localparam logic [SW-1:0]    NIL     = SW'(SLOTS);
    localparam logic [ORD_W-1:0] TOP_ORD = ORD_W'(HEAP_ORDER);
    localparam logic [ORD_W-1:0] MIN_O   = ORD_W'(MIN_ORD);

    bud_state_t state_reg, state_next;

    logic [SW-1:0]    heads_reg [HEAP_ORDER+1];
    logic             hd_we;
    logic [HI_W-1:0]  hd_idx;
    logic [SW-1:0]    hd_wdata;
    logic [SW-1:0]    head_rd;

    logic [31:0]      heap_base_reg;
    logic [31:0]      req_size_reg, req_size_next;
    logic [31:0]      free_addr_reg, free_addr_next;
    logic [31:0]      off_reg, off_next;
    logic [ORD_W-1:0] want_reg, want_next;
    logic [ORD_W-1:0] ord_reg, ord_next;
    logic [SB-1:0]    slot_reg, slot_next;
    logic [SB-1:0]    bud_reg, bud_next;
    logic [SW-1:0]    bnext_reg, bnext_next;
    logic [ORD_W-1:0] bord_reg, bord_next;
    logic [SW-1:0]    cur_reg, cur_next;
    logic [SW-1:0]    steps_reg, steps_next;
    logic             done_reg, done_next;
    logic             status_reg, status_next;
    logic [31:0]      addr_reg, addr_next;
    logic             slot0_wr_reg;
    logic             rd_zero_reg;

    logic             ram_we, ram_re;
    logic [SB-1:0]    ram_waddr, ram_raddr;
    logic [HW-1:0]    ram_wdata, ram_rdata, rd_eff;
    logic [SW-1:0]    rd_nxt;
    logic             rd_fre;
    logic [ORD_W-1:0] rd_ord;

    logic [32:0]      need_bytes;
    logic [ORD_W-1:0] ord_dn;
    logic [31:0]      off_calc;
    logic [31:0]      grant_addr;

    bud_ram #(.WIDTH(HW), .DEPTH(SLOTS)) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // slot 0 reads as the whole free heap until first written
    assign rd_eff = rd_zero_reg ? {NIL, 1'b1, TOP_ORD} : ram_rdata;
    assign rd_nxt = rd_eff[HW-1 -: SW];
    assign rd_fre = rd_eff[ORD_W];
    assign rd_ord = rd_eff[ORD_W-1:0];

    assign need_bytes = {1'b0, req_size_reg} + 33'(HEADER_BYTES);
    assign ord_dn     = ord_reg - 1'b1;
    assign off_calc   = free_addr_reg - heap_base_reg - 32'(HEADER_BYTES);
    assign grant_addr = heap_base_reg + (32'(slot_reg) << MIN_ORD) + 32'(HEADER_BYTES);
    assign hd_idx     = (state_reg == ST_SPLIT) ? HI_W'(ord_dn) : HI_W'(ord_reg);
    assign head_rd    = heads_reg[hd_idx];

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign status    = status_reg;
    assign addr      = addr_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_size_next  = req_size_reg;
        free_addr_next = free_addr_reg;
        off_next       = off_reg;
        want_next      = want_reg;
        ord_next       = ord_reg;
        slot_next      = slot_reg;
        bud_next       = bud_reg;
        bnext_next     = bnext_reg;
        bord_next      = bord_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        addr_next      = addr_reg;
        hd_we          = 1'b0;
        hd_wdata       = head_rd;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = slot_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_size_next  = req_size;
                    free_addr_next = free_addr;
                    want_next      = '0;
                    state_next     = (func == FUNC_FREE) ? ST_FCHK : ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                if (want_reg > TOP_ORD)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_NOMEM;
                    addr_next   = '0;
                    state_next  = ST_IDLE;
                end
                else if ((33'd1 << want_reg) >= need_bytes)
                begin
                    ord_next   = want_reg;
                    state_next = ST_SCAN;
                end
                else
                begin
                    want_next = want_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (ord_reg > TOP_ORD)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_NOMEM;
                    addr_next   = '0;
                    state_next  = ST_IDLE;
                end
                else if (head_rd[SB])
                begin
                    ord_next = ord_reg + 1'b1;
                end
                else
                begin
                    slot_next  = head_rd[SB-1:0];
                    ram_re     = 1'b1;
                    ram_raddr  = head_rd[SB-1:0];
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (!rd_fre)
                begin
                    ord_next   = ord_reg + 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    hd_we      = 1'b1;
                    hd_wdata   = rd_nxt;
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                ram_we = 1'b1;
                if (ord_reg > want_reg)
                begin
                    // push the right half onto the list one order down
                    ord_next  = ord_dn;
                    ram_waddr = slot_reg + (SB'(1) << (ord_dn - MIN_O));
                    ram_wdata = {head_rd, 1'b1, ord_dn};
                    hd_we     = 1'b1;
                    hd_wdata  = {1'b0, ram_waddr};
                end
                else
                begin
                    ram_waddr   = slot_reg;
                    ram_wdata   = {NIL, 1'b0, want_reg};
                    done_next   = 1'b1;
                    // an address that wraps to null reads as a failed allocate
                    status_next = (grant_addr == 32'd0) ? STATUS_NOMEM : STATUS_DONE;
                    addr_next   = grant_addr;
                    state_next  = ST_IDLE;
                end
            end
            ST_FCHK:
            begin
                off_next = off_calc;
                if ((free_addr_reg == 32'd0) || ((off_calc >> HEAP_ORDER) != 32'd0) ||
                    (off_calc[MIN_ORD-1:0] != '0))
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_DONE;
                    addr_next   = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    slot_next  = off_calc[HEAP_ORDER-1:MIN_ORD];
                    ram_re     = 1'b1;
                    ram_raddr  = off_calc[HEAP_ORDER-1:MIN_ORD];
                    state_next = ST_FRD;
                end
            end
            ST_FRD:
            begin
                if (rd_fre || (rd_ord < MIN_O) || (rd_ord > TOP_ORD) ||
                    ((off_reg & ((32'd1 << rd_ord) - 32'd1)) != 32'd0))
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_DONE;
                    addr_next   = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ord_next   = rd_ord;
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (ord_reg >= TOP_ORD)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    bud_next   = slot_reg ^ (SB'(1) << (ord_reg - MIN_O));
                    ram_re     = 1'b1;
                    ram_raddr  = bud_next;
                    state_next = ST_MRD;
                end
            end
            ST_MRD:
            begin
                // record the merged order in the header of the current block
                ram_we     = 1'b1;
                ram_waddr  = slot_reg;
                ram_wdata  = {NIL, 1'b0, ord_reg};
                bnext_next = rd_nxt;
                bord_next  = rd_ord;
                if (!rd_fre || (rd_ord != ord_reg))
                begin
                    state_next = ST_PUSH;
                end
                else if (head_rd == {1'b0, bud_reg})
                begin
                    hd_we      = 1'b1;
                    hd_wdata   = rd_nxt;
                    state_next = ST_UNL_END;
                end
                else
                begin
                    cur_next   = head_rd;
                    steps_next = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (cur_reg[SB] || (steps_reg >= SW'(SLOTS)))
                begin
                    state_next = ST_UNL_END;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = cur_reg[SB-1:0];
                    state_next = ST_WRD;
                end
            end
            ST_WRD:
            begin
                if (rd_nxt == {1'b0, bud_reg})
                begin
                    // bypass the buddy in its predecessor
                    ram_we     = 1'b1;
                    ram_waddr  = cur_reg[SB-1:0];
                    ram_wdata  = {bnext_reg, rd_fre, rd_ord};
                    state_next = ST_UNL_END;
                end
                else
                begin
                    cur_next   = rd_nxt;
                    steps_next = steps_reg + 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_UNL_END:
            begin
                ram_we     = 1'b1;
                ram_waddr  = bud_reg;
                ram_wdata  = {NIL, 1'b0, bord_reg};
                slot_next  = (bud_reg < slot_reg) ? bud_reg : slot_reg;
                ord_next   = ord_reg + 1'b1;
                state_next = ST_MERGE;
            end
            ST_PUSH:
            begin
                ram_we      = 1'b1;
                ram_waddr   = slot_reg;
                ram_wdata   = {head_rd, 1'b1, ord_reg};
                hd_we       = 1'b1;
                hd_wdata    = {1'b0, slot_reg};
                done_next   = 1'b1;
                status_next = STATUS_DONE;
                addr_next   = '0;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            heap_base_reg <= '0;
            slot0_wr_reg  <= 1'b0;
            rd_zero_reg   <= 1'b0;
            for (int i = 0; i <= HEAP_ORDER; i++)
            begin
                heads_reg[i] <= (i == HEAP_ORDER) ? '0 : NIL;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                heap_base_reg <= cfg_data;
            end
            if (ram_we && (ram_waddr == '0))
            begin
                slot0_wr_reg <= 1'b1;
            end
            if (ram_re)
            begin
                rd_zero_reg <= (ram_raddr == '0) && !slot0_wr_reg;
            end
            if (hd_we)
            begin
                heads_reg[hd_idx] <= hd_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_size_reg  <= req_size_next;
        free_addr_reg <= free_addr_next;
        off_reg       <= off_next;
        want_reg      <= want_next;
        ord_reg       <= ord_next;
        slot_reg      <= slot_next;
        bud_reg       <= bud_next;
        bnext_reg     <= bnext_next;
        bord_reg      <= bord_next;
        cur_reg       <= cur_next;
        steps_reg     <= steps_next;
        status_reg    <= status_next;
        addr_reg      <= addr_next;
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_nomem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (addr == 32'd0))
        else $error("failed allocate returned an address");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("header RAM read and write in one cycle");

endmodule

### bench/buddy_allocator_test.sv
// ----------------------------------------------------------------------------
// buddy_allocator_test
// Drives allocate and free requests into the buddy allocator and checks every
// result word against a free-list shadow of the heap kept in the bench (typed
// table rows against their own values). A short table covers extremes and the
// ignored-free cases, then random traffic runs over several heap base values.
// ----------------------------------------------------------------------------
module buddy_allocator_test;

    import bud_pkg::*;

    localparam int HORD      = DEF_HEAP_ORDER;
    localparam int HDR       = DEF_HEADER_BYTES;
    localparam int MORD      = 4;
    localparam int SLOTS     = 1 << (HORD - MORD);
    localparam int NO_SLOT   = SLOTS;
    localparam int IDLE_MAX  = 300000;
    localparam int PHASE_LEN = 180;

    typedef struct {
        logic        fn;
        logic [31:0] sz;
        logic [31:0] fa;
        bit          typed;
        logic        st;
        logic [31:0] ad;
    } stim_row_t;

    typedef struct {
        logic        st;
        logic [31:0] ad;
    } grant_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        func = FUNC_ALLOC;
    logic [31:0] req_size = '0;
    logic [31:0] free_addr = '0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        busy;
    logic        done;
    logic        status;
    logic [31:0] addr;
    logic        cfg_ready;

    // shadow of the allocator state
    logic [31:0] base_shadow;
    int          head_slot [0:HORD];
    int          slot_next [0:SLOTS-1];
    bit          slot_free [0:SLOTS-1];
    int          slot_ord  [0:SLOTS-1];
    bit          slot_seen [0:SLOTS-1];
    int          live_slots [$];

    grant_t      pending_grants [$];
    int          errors = 0;
    int          idle_cycles = 0;

    stim_row_t   directed [] = '{
        '{FUNC_ALLOC, 32'd0,          32'd0,  1, STATUS_DONE,  32'd16},
        '{FUNC_ALLOC, 32'hFFFF_FFFF,  32'd0,  1, STATUS_NOMEM, 32'd0},
        '{FUNC_ALLOC, 32'hFFFF_FFF0,  32'd0,  1, STATUS_NOMEM, 32'd0},
        '{FUNC_ALLOC, 32'd65521,      32'd0,  1, STATUS_NOMEM, 32'd0},
        '{FUNC_FREE,  32'd0,          32'd0,  1, STATUS_DONE,  32'd0},
        '{FUNC_FREE,  32'hFFFF_FFFF,  32'd5,  1, STATUS_DONE,  32'd0},
        '{FUNC_FREE,  32'd0,          32'd24, 1, STATUS_DONE,  32'd0},
        '{FUNC_FREE,  32'd0,          32'd32, 1, STATUS_DONE,  32'd0},
        '{FUNC_FREE,  32'd0,          32'hFFFF_FFFF, 1, STATUS_DONE, 32'd0},
        '{FUNC_ALLOC, 32'd16,         32'd0,  0, STATUS_DONE,  32'd0},
        '{FUNC_ALLOC, 32'd1000,       32'd0,  0, STATUS_DONE,  32'd0},
        '{FUNC_ALLOC, 32'd65520,      32'd0,  0, STATUS_DONE,  32'd0},
        '{FUNC_FREE,  32'd0,          32'd1040, 0, STATUS_DONE, 32'd0},
        '{FUNC_FREE,  32'd0,          32'd48, 0, STATUS_DONE,  32'd0},
        '{FUNC_FREE,  32'd0,          32'd16, 0, STATUS_DONE,  32'd0},
        '{FUNC_FREE,  32'd0,          32'd16, 0, STATUS_DONE,  32'd0},
        '{FUNC_ALLOC, 32'd65520,      32'd0,  1, STATUS_DONE,  32'd16},
        '{FUNC_ALLOC, 32'd0,          32'd0,  1, STATUS_NOMEM, 32'd0},
        '{FUNC_FREE,  32'd0,          32'd16, 1, STATUS_DONE,  32'd0},
        '{FUNC_ALLOC, 32'd48,         32'd0,  0, STATUS_DONE,  32'd0}
    };

    buddy_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .req_size  (req_size),
        .free_addr (free_addr),
        .done      (done),
        .status    (status),
        .addr      (addr),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic void push_block(input int slot, input int ord);
        slot_next[slot] = head_slot[ord];
        slot_free[slot] = 1'b1;
        slot_ord[slot]  = ord;
        slot_seen[slot] = 1'b1;
        head_slot[ord]  = slot;
    endfunction

    function automatic void unlink_block(input int slot, input int ord);
        int cur;
        int steps;
        cur   = head_slot[ord];
        steps = 0;
        slot_free[slot] = 1'b0;
        if (cur == slot)
        begin
            head_slot[ord] = slot_next[slot];
        end
        else
        begin
            while (cur < SLOTS && steps < SLOTS)
            begin
                if (slot_next[cur] == slot)
                begin
                    slot_next[cur] = slot_next[slot];
                    break;
                end
                cur = slot_next[cur];
                steps++;
            end
        end
        slot_next[slot] = NO_SLOT;
    endfunction

    function automatic void heap_reset();
        for (int i = 0; i <= HORD; i++)
        begin
            head_slot[i] = NO_SLOT;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_next[i] = 0;
            slot_free[i] = 1'b0;
            slot_ord[i]  = 0;
            slot_seen[i] = 1'b0;
        end
        base_shadow = '0;
        push_block(0, HORD);
        slot_next[0] = NO_SLOT;
    endfunction

    // apply one request to the shadow heap and return the result word
    function automatic grant_t heap_predict(input logic fn, input logic [31:0] sz,
                                            input logic [31:0] fa);
        grant_t           g;
        longint unsigned  need;
        int               want;
        int               o;
        int               s;
        int               b;
        logic [31:0]      off;
        g.st = STATUS_DONE;
        g.ad = '0;
        if (fn == FUNC_ALLOC)
        begin
            g.st = STATUS_NOMEM;
            need = longint'(sz) + HDR;
            want = 0;
            while (want < 40 && (64'd1 << want) < need)
            begin
                want++;
            end
            o = want;
            while (o <= HORD)
            begin
                s = head_slot[o];
                if (s < SLOTS && slot_free[s])
                begin
                    head_slot[o] = slot_next[s];
                    while (o > want)
                    begin
                        o--;
                        push_block(s + (1 << (o - MORD)), o);
                    end
                    slot_free[s] = 1'b0;
                    slot_ord[s]  = want;
                    slot_next[s] = NO_SLOT;
                    slot_seen[s] = 1'b1;
                    g.ad = base_shadow + (s << MORD) + HDR;
                    g.st = (g.ad == 0) ? STATUS_NOMEM : STATUS_DONE;
                    live_slots.push_back(s);
                    break;
                end
                o++;
            end
        end
        else if (fa != 0)
        begin
            off = fa - base_shadow - HDR;
            if (off < (32'd1 << HORD) && off[MORD-1:0] == 0)
            begin
                s = off >> MORD;
                o = slot_ord[s];
                if (!slot_free[s] && o >= MORD && o <= HORD
                    && (off & ((32'd1 << o) - 1)) == 0)
                begin
                    foreach (live_slots[i])
                    begin
                        if (live_slots[i] == s)
                        begin
                            live_slots.delete(i);
                            break;
                        end
                    end
                    while (o < HORD)
                    begin
                        b = s ^ (1 << (o - MORD));
                        if (!slot_free[b] || slot_ord[b] != o)
                        begin
                            break;
                        end
                        unlink_block(b, o);
                        if (b < s)
                        begin
                            s = b;
                        end
                        o++;
                        slot_ord[s] = o;
                    end
                    push_block(s, o);
                end
            end
        end
        return g;
    endfunction

    // a stray free may only hit a header that is known to read back as free
    function automatic logic [31:0] stray_free_addr(input logic [31:0] fa);
        logic [31:0] off;
        off = fa - base_shadow - HDR;
        if (fa == 0 || off >= (32'd1 << HORD) || off[MORD-1:0] != 0)
        begin
            return fa;
        end
        if (slot_seen[off >> MORD] && slot_free[off >> MORD])
        begin
            return fa;
        end
        return base_shadow + (32'd1 << HORD) + HDR;
    endfunction

    task automatic issue(input logic fn, input logic [31:0] sz, input logic [31:0] fa,
                         input bit typed, input logic st, input logic [31:0] ad);
        grant_t g;
        start     <= 1'b1;
        func      <= fn;
        req_size  <= sz;
        free_addr <= fa;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        g = heap_predict(fn, sz, fa);
        if (typed)
        begin
            g.st = st;
            g.ad = ad;
        end
        pending_grants.push_back(g);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_grants.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_base(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        base_shadow = v;
    endtask

    task automatic random_item();
        int          pick;
        int          idx;
        logic [31:0] fa;
        pick = $urandom_range(0, 99);
        if (pick < 55 || (pick < 90 && live_slots.size() == 0))
        begin
            issue(FUNC_ALLOC, $urandom_range(0, (32'd1 << $urandom_range(0, 15)) - 1),
                  $urandom, 0, STATUS_DONE, 0);
        end
        else if (pick < 60)
        begin
            issue(FUNC_ALLOC, $urandom, $urandom, 0, STATUS_DONE, 0);
        end
        else if (pick < 90)
        begin
            idx = $urandom_range(0, live_slots.size() - 1);
            fa  = base_shadow + (live_slots[idx] << MORD) + HDR;
            // a block whose address wrapped to null can never be released
            if (fa == 0)
            begin
                live_slots.delete(idx);
            end
            issue(FUNC_FREE, $urandom, fa, 0, STATUS_DONE, 0);
        end
        else
        begin
            issue(FUNC_FREE, $urandom, stray_free_addr($urandom), 0, STATUS_DONE, 0);
        end
    endtask

    // check each result word against the oldest prediction
    always @(posedge clk)
    begin
        grant_t g;
        if (done)
        begin
            if (pending_grants.size() == 0)
            begin
                $error("unexpected result word: status %0d addr %h", status, addr);
                errors++;
            end
            else
            begin
                g = pending_grants.pop_front();
                if (status !== g.st)
                begin
                    $error("status: expected %0d actual %0d", g.st, status);
                    errors++;
                end
                if (addr !== g.ad)
                begin
                    $error("addr: expected %h actual %h", g.ad, addr);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("buddy_allocator_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] bases [5];
        int          burst;
        bases = '{32'd0, 32'hFFFF_FFF0, $urandom & 32'hFFFF_FFF8, 32'hFFFF_FFF8, 32'd0};
        heap_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            issue(directed[i].fn, directed[i].sz, directed[i].fa, directed[i].typed,
                  directed[i].st, directed[i].ad);
        end
        drain();

        foreach (bases[p])
        begin
            write_base(bases[p]);
            burst = $urandom_range(1, 12);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                random_item();
                if (n == PHASE_LEN / 2)
                begin
                    // hold off until the block has answered everything
                    drain();
                end
                else if (--burst == 0)
                begin
                    burst = $urandom_range(1, 12);
                    if ($urandom_range(0, 3) != 0)
                    begin
                        start <= 1'b0;
                        repeat ($urandom_range(1, 40)) @(posedge clk);
                    end
                end
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (errors == 0 && pending_grants.size() == 0)
        begin
            $display("buddy_allocator_test OK");
        end
        else
        begin
            $display("buddy_allocator_test NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
hdl/bud_pkg.sv
hdl/bud_ram.sv
hdl/buddy_allocator.sv
bench/buddy_allocator_test.sv
